/* rtl/six_step_commutation_duty_slew_defines.svh */
// Assertion macros shared by the six-step commutation RTL.
// Depends on nothing; files that check their logic include it.
`ifndef SIX_STEP_COMMUTATION_DUTY_SLEW_DEFINES_SVH
`define SIX_STEP_COMMUTATION_DUTY_SLEW_DEFINES_SVH

// Concurrent check on the rising clock, disabled while reset is asserted.
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/ssc_pkg.sv */
// Shared widths, register indices and the hall vote for the six-step block.
// Depends on nothing; used by the divider and the top level.
package ssc_pkg;

  localparam int THR_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int HALL_W     = 3;
  localparam int HALL_READS = 8;
  localparam int READS_W    = 8;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 64;

  // Divider geometry: the numerator is an 8-bit value shifted up by 8 bits.
  localparam int QUO_W  = 16;
  localparam int DIVR_W = 8;
  localparam int CNT_W  = $clog2(QUO_W);

  // Configuration register indices.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd4;

  localparam logic [BYTE_W-1:0] LEVEL_MAX = 8'd255;

  // Majority vote over the oversampled reads of one hall line.
  function automatic logic hall_vote(input logic [READS_W-1:0] reads);
    logic [4:0] cnt;
    cnt = '0;
    for (int i = 0; i < HALL_READS; i++) begin
      cnt = cnt + 5'(reads[i]);
    end
    return cnt > 5'(HALL_READS / 2);
  endfunction

endpackage

/* rtl/six_step_commutation_duty_slew.sv */
// Top level of the six-step commutation block with throttle scaling and duty slew.
// Depends on ssc_pkg and instantiates the bit-serial divider ssc_div.
// Sequence: accept an item, prepare the offset and scale operands, run the 16-step divider,
// then register the result; the division is skipped when the scaled throttle is forced to zero.
// A new item is taken only after the last result has entered the result register; result stalls hold it.
// Reset: asynchronous, active low; configuration registers return to defaults, offset and duty clear.
`include "six_step_commutation_duty_slew_defines.svh"

module six_step_commutation_duty_slew import ssc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Bits from 0 up: throttle_sample, hall_one_reads, hall_two_reads, hall_three_reads,
  // system_ready, overcurrent_fault, zero padding.
  input  logic [IN_W-1:0]      s_axis_tdata,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Bits from 0 up: phase_a_high_level, phase_a_low_level, phase_b_high_level,
  // phase_b_low_level, phase_c_high_level, phase_c_low_level, applied_duty,
  // hall_state, zero padding.
  output logic [OUT_W-1:0]     m_axis_tdata,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [BYTE_W-1:0] floor_q, step_q, margin_q, cap_q, full_q;

  // Captured item and running state.
  logic [BYTE_W-1:0] byte_q;
  logic [HALL_W-1:0] hall_q;
  logic              ready_q, fault_q, zero_q, zero_d;
  logic [BYTE_W-1:0] offset_q, offset_d;
  logic [BYTE_W-1:0] duty_q;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic              in_fire, out_free;
  logic              div_start, div_done;
  logic [QUO_W-1:0]  quotient;

  logic [BYTE_W-1:0] off_new;
  logic [BYTE_W:0]   num, den;

  logic [QUO_W-1:0]  scaled, target_w;
  logic [BYTE_W-1:0] target, duty, comp, room;
  logic [BYTE_W-1:0] hi [3];
  logic [BYTE_W-1:0] lo [3];
  logic [OUT_W-1:0]  out_data_d;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes; indices beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= 8'd35;
      step_q   <= 8'd1;
      margin_q <= 8'd6;
      cap_q    <= 8'd170;
      full_q   <= 8'd166;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DUTY_FLOOR:  floor_q  <= cfg_data_i;
        REG_SLEW_STEP:   step_q   <= cfg_data_i;
        REG_DEAD_MARGIN: margin_q <= cfg_data_i;
        REG_OFFSET_CAP:  cap_q    <= cfg_data_i;
        REG_FULL_SCALE:  full_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the throttle byte and vote the hall lines when an item arrives.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q  <= s_axis_tdata[THR_W-1:THR_W-BYTE_W];
      hall_q  <= {hall_vote(s_axis_tdata[35:28]), hall_vote(s_axis_tdata[27:20]),
                  hall_vote(s_axis_tdata[19:12])};
      ready_q <= s_axis_tdata[36];
      fault_q <= s_axis_tdata[37];
    end
  end

  // Offset capture with cap, and the numerator and divisor of the scale.
  always_comb begin
    off_new = (offset_q == '0) ? byte_q : offset_q;
    if (off_new > cap_q) begin
      off_new = cap_q;
    end
    num = {1'b0, byte_q} - {1'b0, off_new};
    den = {1'b0, full_q} - {1'b0, off_new};
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    offset_d  = offset_q;
    zero_d    = zero_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!ready_q) begin
          zero_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          offset_d = off_new;
          if (num[BYTE_W] || num == '0 || den[BYTE_W] || den == '0) begin
            zero_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            zero_d    = 1'b0;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ssc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num[BYTE_W-1:0], {BYTE_W{1'b0}}}),
    .divisor_i  (den[BYTE_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Floor, clamp, slew, complement and the six-step drive table.
  always_comb begin
    scaled   = zero_q ? '0 : quotient;
    target_w = (scaled > QUO_W'(floor_q)) ? scaled - QUO_W'(floor_q) : '0;
    target   = (target_w > QUO_W'(LEVEL_MAX)) ? LEVEL_MAX : target_w[BYTE_W-1:0];

    duty = duty_q;
    if (target > duty_q) begin
      duty = (target - duty_q > step_q) ? duty_q + step_q : target;
    end else if (target < duty_q) begin
      duty = (duty_q - target > step_q) ? duty_q - step_q : target;
    end

    room = LEVEL_MAX - duty;
    comp = (room > margin_q) ? room - margin_q : '0;

    for (int k = 0; k < 3; k++) begin
      hi[k] = '0;
      lo[k] = '0;
    end
    case (hall_q)
      3'd1: begin hi[0] = duty; lo[0] = comp; lo[2] = LEVEL_MAX; end
      3'd2: begin hi[2] = duty; lo[1] = LEVEL_MAX; lo[2] = comp; end
      3'd3: begin hi[0] = duty; lo[0] = comp; lo[1] = LEVEL_MAX; end
      3'd4: begin hi[1] = duty; lo[0] = LEVEL_MAX; lo[1] = comp; end
      3'd5: begin hi[1] = duty; lo[1] = comp; lo[2] = LEVEL_MAX; end
      3'd6: begin hi[2] = duty; lo[0] = LEVEL_MAX; lo[2] = comp; end
      default: ;
    endcase

    out_data_d = '0;
    if (ready_q && !fault_q) begin
      for (int k = 0; k < 3; k++) begin
        out_data_d[16*k +: BYTE_W]     = hi[k];
        out_data_d[16*k + 8 +: BYTE_W] = LEVEL_MAX - lo[k];
      end
    end
    out_data_d[55:48] = duty;
    out_data_d[58:56] = hall_q;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= '0;
      zero_q      <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      zero_q   <= zero_d;
      if (state_q == ST_DONE && out_free) begin
        duty_q      <= duty;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SSC_ASSERT(a_accept_starts_prep, in_fire |=> state_q == ST_PREP,
              "accepted item did not start the sequencer")
  `SSC_ASSERT(a_done_only_in_div, div_done |-> state_q == ST_DIV,
              "divider finished outside the divide step")
  `SSC_ASSERT(a_one_high_side, m_axis_tvalid |->
              $onehot0({m_axis_tdata[7:0] != 8'd0, m_axis_tdata[23:16] != 8'd0,
                        m_axis_tdata[39:32] != 8'd0}),
              "more than one high side driven")

endmodule

/* rtl/ssc_div.sv */
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on ssc_pkg for its widths.
`include "six_step_commutation_duty_slew_defines.svh"

module ssc_div import ssc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUO_W-1:0]  dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] divisor_q, divisor_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    quo_d     = quo_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      rem_d     = '0;
      divisor_d = divisor_i;
      quo_d     = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DIVR_W'(trial - {1'b0, divisor_q}) : trial[DIVR_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    quo_q     <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `SSC_ASSERT(a_div_no_restart, start_i |-> !busy_q, "divider restarted while busy")
  `SSC_ASSERT(a_div_done_after_busy, done_q |-> !busy_q && $past(busy_q),
              "divider done without a finished run")
  `SSC_ASSERT_ALWAYS(a_div_rem_below, !busy_q || rem_q < divisor_q,
                     "remainder not below the divisor during a division")

endmodule
